// ----- src/swr_pkg.sv -----
// ----------------------------------------------------------------------------
// Stop-and-wait receiver package
// Message type codes, phase codes, the result bundle and the 8-bit
// ones'-complement add.
// ----------------------------------------------------------------------------
package swr_pkg;

    localparam logic [7:0] TYPE_ACK          = 8'h01;
    localparam logic [7:0] TYPE_FIRST_SHAKE  = 8'h03;
    localparam logic [7:0] TYPE_SECOND_SHAKE = 8'h04;
    localparam logic [7:0] TYPE_THIRD_SHAKE  = 8'h05;
    localparam logic [7:0] TYPE_FIRST_WAVE   = 8'h06;
    localparam logic [7:0] TYPE_SECOND_WAVE  = 8'h07;
    localparam logic [7:0] TYPE_LAST         = 8'h08;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_THIRD = 3'd1;
    localparam logic [2:0] PH_XFER  = 3'd2;
    localparam logic [2:0] PH_WAVE  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;
    localparam logic [2:0] PH_ERROR = 3'd5;

    localparam logic [1:0] LEN_ACK   = 2'd3;
    localparam logic [1:0] LEN_SHORT = 2'd2;
    localparam logic [2:0] OFS_LAST  = 3'd4;
    localparam logic [2:0] OFS_DATA  = 3'd3;

    typedef struct packed {
        logic       send_reply;
        logic [7:0] reply_type;
        logic [7:0] reply_seq;
        logic [7:0] reply_check;
        logic [1:0] reply_len;
        logic       accepted;
        logic [2:0] payload_offset;
        logic [8:0] payload_length;
        logic       message_end;
        logic [2:0] phase_now;
    } t_result;

    function automatic logic [7:0] oc_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            oc_add = s[7:0] + {7'd0, s[8]};
        end
    endfunction

endpackage

// ----- src/swr_core.sv -----
// ----------------------------------------------------------------------------
// Stop-and-wait receiver core
// Per-byte checksum and header capture, protocol phase tracking and the
// reply decision at each datagram end.
// ----------------------------------------------------------------------------
module swr_core #(
    parameter int DATA_DATAGRAM_BYTES = 513,
    parameter int PAYLOAD_MAX         = 509,
    parameter int MESSAGES            = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_end_of_datagram,
    output swr_pkg::t_result o_result
);
    import swr_pkg::*;

    localparam int IDX_W = $clog2(DATA_DATAGRAM_BYTES + 1);
    localparam logic [IDX_W-1:0] DATA_SIZE  = IDX_W'(DATA_DATAGRAM_BYTES);
    localparam logic [IDX_W-1:0] SHORT_SIZE = IDX_W'(2);
    localparam logic [10:0] PMAX = 11'(PAYLOAD_MAX);
    localparam logic [2:0]  MSGS = 3'(MESSAGES);

    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_exp_seq, n_exp_seq;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_len, n_len;
    logic [1:0]       r_msgs, n_msgs;

    logic             in_range;
    logic             chk_ok;
    logic             acc;
    logic [7:0]       ack_seq;
    logic [8:0]       last_len;
    t_result          res;

    always_comb begin
        in_range = r_idx < ((r_phase == PH_XFER) ? DATA_SIZE : SHORT_SIZE);
        n_sum  = in_range ? oc_add(r_sum, i_rx_byte) : r_sum;
        n_type = (in_range && r_idx == IDX_W'(1)) ? i_rx_byte : r_type;
        n_seq  = (in_range && r_idx == IDX_W'(2)) ? i_rx_byte : r_seq;
        n_len  = (in_range && r_idx == IDX_W'(3)) ? i_rx_byte : r_len;
        n_idx  = in_range ? r_idx + IDX_W'(1) : r_idx;

        chk_ok  = (n_sum == 8'hFF);
        acc     = chk_ok && (n_seq == r_exp_seq);
        ack_seq = acc ? r_exp_seq : r_exp_seq - 8'd1;
        last_len = ({3'd0, n_len} > PMAX) ? PMAX[8:0] : {1'b0, n_len};

        n_phase   = r_phase;
        n_exp_seq = r_exp_seq;
        n_msgs    = r_msgs;
        res       = '0;

        case (r_phase)
            PH_IDLE: begin
                if (chk_ok && n_type == TYPE_FIRST_SHAKE) begin
                    res.send_reply  = 1'b1;
                    res.reply_type  = TYPE_SECOND_SHAKE;
                    res.reply_check = ~TYPE_SECOND_SHAKE;
                    res.reply_len   = LEN_SHORT;
                    n_phase         = PH_THIRD;
                end
            end
            PH_THIRD: begin
                if (chk_ok && n_type == TYPE_FIRST_SHAKE) begin
                    res.send_reply  = 1'b1;
                    res.reply_type  = TYPE_SECOND_SHAKE;
                    res.reply_check = ~TYPE_SECOND_SHAKE;
                    res.reply_len   = LEN_SHORT;
                end else if (chk_ok && n_type == TYPE_THIRD_SHAKE) begin
                    n_phase = PH_XFER;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_XFER: begin
                res.send_reply  = 1'b1;
                res.reply_type  = TYPE_ACK;
                res.reply_seq   = ack_seq;
                res.reply_check = ~oc_add(TYPE_ACK, ack_seq);
                res.reply_len   = LEN_ACK;
                if (acc) begin
                    n_exp_seq    = r_exp_seq + 8'd1;
                    res.accepted = 1'b1;
                    if (n_type == TYPE_LAST) begin
                        res.payload_offset = OFS_LAST;
                        res.payload_length = last_len;
                        res.message_end    = 1'b1;
                        n_msgs             = r_msgs + 2'd1;
                        if ({1'b0, n_msgs} >= MSGS) begin
                            n_phase = PH_WAVE;
                        end
                    end else begin
                        res.payload_offset = OFS_DATA;
                        res.payload_length = PMAX[8:0];
                    end
                end
            end
            PH_WAVE: begin
                if (chk_ok && n_type == TYPE_FIRST_WAVE) begin
                    res.send_reply  = 1'b1;
                    res.reply_type  = TYPE_SECOND_WAVE;
                    res.reply_check = ~TYPE_SECOND_WAVE;
                    res.reply_len   = LEN_SHORT;
                    n_phase         = PH_DONE;
                end
            end
            default: begin
            end
        endcase
        res.phase_now = n_phase;
        o_result      = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_exp_seq <= '0;
            r_msgs    <= '0;
            r_idx     <= '0;
            r_sum     <= '0;
            r_type    <= '0;
            r_seq     <= '0;
            r_len     <= '0;
        end else if (i_fire) begin
            if (i_end_of_datagram) begin
                // commit protocol state, clear datagram capture
                r_phase   <= n_phase;
                r_exp_seq <= n_exp_seq;
                r_msgs    <= n_msgs;
                r_idx     <= '0;
                r_sum     <= '0;
                r_type    <= '0;
                r_seq     <= '0;
                r_len     <= '0;
            end else begin
                r_idx  <= n_idx;
                r_sum  <= n_sum;
                r_type <= n_type;
                r_seq  <= n_seq;
                r_len  <= n_len;
            end
        end
    end

endmodule

// ----- src/stop_and_wait_receiver.sv -----
// ----------------------------------------------------------------------------
// Stop-and-wait receiver
// Byte-serial receive side of a stop-and-wait ARQ link with handshake and
// close.
// ----------------------------------------------------------------------------
// Takes one datagram byte per cycle, header first, with the last byte of each
// datagram marked. Every datagram end yields one result transfer: a reply
// request (second shake, ACK or second wave) plus acceptance, payload offset,
// payload length and the phase reached. Bytes beyond the datagram size are
// ignored and missing bytes count as zero. Throughput is one byte per cycle;
// the final byte passes through the input register, and the result is then
// held in the result register. Only a stalled result holds back the input
// side, and only when the next byte ends a datagram.
module stop_and_wait_receiver #(
    parameter int DATA_DATAGRAM_BYTES = 513,
    parameter int PAYLOAD_MAX         = 509,
    parameter int MESSAGES            = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_end_of_datagram,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_send_reply,
    output logic [7:0] o_reply_type,
    output logic [7:0] o_reply_seq,
    output logic [7:0] o_reply_check,
    output logic [1:0] o_reply_len,
    output logic       o_accepted,
    output logic [2:0] o_payload_offset,
    output logic [8:0] o_payload_length,
    output logic       o_message_end,
    output logic [2:0] o_phase_now
);
    import swr_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_res;
    logic       fire;

    assign o_stall = r_in_valid && r_in_end && r_out_valid && i_stall;
    assign fire    = r_in_valid && !o_stall;

    swr_core #(
        .DATA_DATAGRAM_BYTES (DATA_DATAGRAM_BYTES),
        .PAYLOAD_MAX         (PAYLOAD_MAX),
        .MESSAGES            (MESSAGES)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_rx_byte         (r_in_byte),
        .i_end_of_datagram (r_in_end),
        .o_result          (core_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
            r_in_end  <= i_end_of_datagram;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_end) begin
            r_out <= core_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_send_reply     = r_out.send_reply;
    assign o_reply_type     = r_out.reply_type;
    assign o_reply_seq      = r_out.reply_seq;
    assign o_reply_check    = r_out.reply_check;
    assign o_reply_len      = r_out.reply_len;
    assign o_accepted       = r_out.accepted;
    assign o_payload_offset = r_out.payload_offset;
    assign o_payload_length = r_out.payload_length;
    assign o_message_end    = r_out.message_end;
    assign o_phase_now      = r_out.phase_now;

endmodule

// ----- verif/swr_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stop-and-wait receiver scoreboard
// Byte-level prediction of the receive protocol (handshake, data messages,
// close) and in-order comparison of every reply transfer against it.
// ----------------------------------------------------------------------------
package swr_tb_pkg;

    import swr_pkg::*;

    localparam int DATA_DATAGRAM_BYTES = 513;
    localparam int PAYLOAD_MAX         = 509;
    localparam int MESSAGES            = 2;

    typedef logic [7:0] octet_q[$];

    function automatic logic [7:0] fold_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[7:0] + {7'd0, total[8]};
    endfunction

    class arq_scoreboard;
        logic [2:0]  phase;
        logic [7:0]  exp_seq;
        logic [9:0]  byte_pos;
        logic [7:0]  sum;
        logic [7:0]  hdr_type;
        logic [7:0]  hdr_seq;
        logic [7:0]  hdr_len;
        logic [1:0]  msgs_done;
        int unsigned accepted_count;
        int unsigned datagram_count;
        int unsigned checked_count;
        int unsigned mismatch_count;
        t_result     reply_q[$];

        function new();
            phase          = PH_IDLE;
            exp_seq        = 8'd0;
            msgs_done      = 2'd0;
            accepted_count = 0;
            datagram_count = 0;
            checked_count  = 0;
            mismatch_count = 0;
            clear_datagram();
        endfunction

        function void clear_datagram();
            byte_pos = 10'd0;
            sum      = 8'd0;
            hdr_type = 8'd0;
            hdr_seq  = 8'd0;
            hdr_len  = 8'd0;
        endfunction

        function void note_byte(input logic [7:0] b, input logic eod);
            t_result    r;
            logic       sum_ok;
            logic       take;
            logic [9:0] size;
            size = (phase == PH_XFER) ? 10'(DATA_DATAGRAM_BYTES) : 10'd2;
            if (byte_pos < size) begin
                sum = fold_add(sum, b);
                case (byte_pos)
                    10'd1: hdr_type = b;
                    10'd2: hdr_seq = b;
                    10'd3: hdr_len = b;
                    default: ;
                endcase
                byte_pos++;
            end
            if (!eod) return;

            r      = '0;
            sum_ok = (sum == 8'hFF);
            case (phase)
                PH_IDLE: begin
                    if (sum_ok && hdr_type == TYPE_FIRST_SHAKE) begin
                        r.send_reply  = 1'b1;
                        r.reply_type  = TYPE_SECOND_SHAKE;
                        r.reply_check = ~TYPE_SECOND_SHAKE;
                        r.reply_len   = LEN_SHORT;
                        phase         = PH_THIRD;
                    end
                end
                PH_THIRD: begin
                    if (sum_ok && hdr_type == TYPE_FIRST_SHAKE) begin
                        r.send_reply  = 1'b1;
                        r.reply_type  = TYPE_SECOND_SHAKE;
                        r.reply_check = ~TYPE_SECOND_SHAKE;
                        r.reply_len   = LEN_SHORT;
                    end else if (sum_ok && hdr_type == TYPE_THIRD_SHAKE) begin
                        phase = PH_XFER;
                    end else begin
                        phase = PH_ERROR;
                    end
                end
                PH_XFER: begin
                    take = sum_ok && (hdr_seq == exp_seq);
                    if (take) begin
                        exp_seq = exp_seq + 8'd1;
                        accepted_count++;
                    end
                    r.send_reply  = 1'b1;
                    r.reply_type  = TYPE_ACK;
                    r.reply_seq   = exp_seq - 8'd1;
                    r.reply_check = ~fold_add(TYPE_ACK, exp_seq - 8'd1);
                    r.reply_len   = LEN_ACK;
                    if (take) begin
                        r.accepted = 1'b1;
                        if (hdr_type == TYPE_LAST) begin
                            r.payload_offset = OFS_LAST;
                            r.payload_length = (int'(hdr_len) > PAYLOAD_MAX) ?
                                               9'(PAYLOAD_MAX) : 9'(hdr_len);
                            r.message_end    = 1'b1;
                            msgs_done        = msgs_done + 2'd1;
                            if (int'(msgs_done) >= MESSAGES) phase = PH_WAVE;
                        end else begin
                            r.payload_offset = OFS_DATA;
                            r.payload_length = 9'(PAYLOAD_MAX);
                        end
                    end
                end
                PH_WAVE: begin
                    if (sum_ok && hdr_type == TYPE_FIRST_WAVE) begin
                        r.send_reply  = 1'b1;
                        r.reply_type  = TYPE_SECOND_WAVE;
                        r.reply_check = ~TYPE_SECOND_WAVE;
                        r.reply_len   = LEN_SHORT;
                        phase         = PH_DONE;
                    end
                end
                default: ;
            endcase
            r.phase_now = phase;
            reply_q.push_back(r);
            datagram_count++;
            clear_datagram();
        endfunction

        task report(input string msg);
            if (mismatch_count < 100) $display("[%0t] MISMATCH %s", $time, msg);
            mismatch_count++;
        endtask

        task compare_field(input string name, input logic [8:0] got, input logic [8:0] want);
            if (got !== want)
                report($sformatf("reply %0d %s: got 0x%0h, expected 0x%0h",
                                 checked_count, name, got, want));
        endtask

        task check_reply(input t_result got);
            t_result want;
            if (reply_q.size() == 0) begin
                report("result transfer with no datagram end outstanding");
                return;
            end
            want = reply_q.pop_front();
            compare_field("send_reply", 9'(got.send_reply), 9'(want.send_reply));
            compare_field("reply_type", 9'(got.reply_type), 9'(want.reply_type));
            compare_field("reply_seq", 9'(got.reply_seq), 9'(want.reply_seq));
            compare_field("reply_check", 9'(got.reply_check), 9'(want.reply_check));
            compare_field("reply_len", 9'(got.reply_len), 9'(want.reply_len));
            compare_field("accepted", 9'(got.accepted), 9'(want.accepted));
            compare_field("payload_offset", 9'(got.payload_offset), 9'(want.payload_offset));
            compare_field("payload_length", got.payload_length, want.payload_length);
            compare_field("message_end", 9'(got.message_end), 9'(want.message_end));
            compare_field("phase_now", 9'(got.phase_now), 9'(want.phase_now));
            checked_count++;
        endtask
    endclass

endpackage

// ----- verif/tb_stop_and_wait_receiver.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stop-and-wait receiver testbench
// Walks the receiver once through idle noise, the three-way handshake, two
// data messages of mostly short datagrams (with stale, corrupt, truncated and
// oversized ones mixed in) and the close, with random idle and stall bursts
// on both sides, checking every reply transfer against a scoreboard.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_receiver;

    import swr_pkg::*;
    import swr_tb_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_rx_byte;
    logic       i_end_of_datagram;
    logic       o_valid;
    logic       i_stall;
    logic       o_send_reply;
    logic [7:0] o_reply_type;
    logic [7:0] o_reply_seq;
    logic [7:0] o_reply_check;
    logic [1:0] o_reply_len;
    logic       o_accepted;
    logic [2:0] o_payload_offset;
    logic [8:0] o_payload_length;
    logic       o_message_end;
    logic [2:0] o_phase_now;

    arq_scoreboard sb;
    int unsigned   cycle_count = 0;
    bit            send_calm   = 1'b0;
    bit            recv_calm   = 1'b0;
    bit            quiet_tail  = 1'b0;

    stop_and_wait_receiver #(
        .DATA_DATAGRAM_BYTES(DATA_DATAGRAM_BYTES),
        .PAYLOAD_MAX(PAYLOAD_MAX),
        .MESSAGES(MESSAGES)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_rx_byte(i_rx_byte),
        .i_end_of_datagram(i_end_of_datagram),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_send_reply(o_send_reply),
        .o_reply_type(o_reply_type),
        .o_reply_seq(o_reply_seq),
        .o_reply_check(o_reply_check),
        .o_reply_len(o_reply_len),
        .o_accepted(o_accepted),
        .o_payload_offset(o_payload_offset),
        .o_payload_length(o_payload_length),
        .o_message_end(o_message_end),
        .o_phase_now(o_phase_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        int unsigned hold;
        hold    = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet_tail || !i_rst_n) begin
                i_stall <= 1'b0;
            end else if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else if (!recv_calm && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                hold = $urandom_range(0, 12);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        cycle_count++;
        if (cycle_count % 256 == 0) begin
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got.send_reply     = o_send_reply;
            got.reply_type     = o_reply_type;
            got.reply_seq      = o_reply_seq;
            got.reply_check    = o_reply_check;
            got.reply_len      = o_reply_len;
            got.accepted       = o_accepted;
            got.payload_offset = o_payload_offset;
            got.payload_length = o_payload_length;
            got.message_end    = o_message_end;
            got.phase_now      = o_phase_now;
            sb.check_reply(got);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eod);
        int unsigned gap;
        @(negedge i_clk);
        if (!quiet_tail && !send_calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_rx_byte         <= b;
        i_end_of_datagram <= eod;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b, eod);
    endtask

    task automatic send_datagram(input octet_q dg);
        foreach (dg[i]) send_byte(dg[i], i == dg.size() - 1);
    endtask

    // hold the sender until every outstanding reply has been checked
    task automatic drain_replies();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.reply_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic octet_q make_packet(input logic [7:0] ptype, input logic [7:0] pseq,
                                           input logic [7:0] plen, input int n_bytes);
        octet_q     body;
        int         span;
        logic [7:0] s;
        body.push_back(ptype);
        body.push_back(pseq);
        body.push_back(plen);
        while (body.size() < n_bytes - 1) body.push_back(8'($urandom));
        while (body.size() > n_bytes - 1) void'(body.pop_back());
        span = (sb.phase == PH_XFER) ? DATA_DATAGRAM_BYTES - 1 : 1;
        s    = 8'h00;
        foreach (body[i]) if (i < span) s = fold_add(s, body[i]);
        body.push_front(~s);
        return body;
    endfunction

    function automatic logic [7:0] pick_data_type();
        logic [7:0] t;
        case ($urandom_range(0, 3))
            0: t = 8'h00;
            1: t = TYPE_ACK;
            2: t = 8'h02;
            default: begin
                do t = 8'($urandom); while (t == TYPE_LAST);
            end
        endcase
        return t;
    endfunction

    initial begin
        octet_q      dg;
        int unsigned pick;
        bit          long_sent;
        long_sent         = 1'b0;
        sb                = new();
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_rx_byte         = 8'h00;
        i_end_of_datagram = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle: noise, then an opening shake with trailing bytes
        send_datagram(make_packet(8'h00, 8'h00, 8'h00, 1));
        send_datagram(make_packet(TYPE_ACK, 8'h00, 8'h00, 2));
        dg = make_packet(TYPE_FIRST_SHAKE, 8'h00, 8'h00, 2);
        dg[0] ^= 8'h01;
        send_datagram(dg);
        send_datagram(make_packet(TYPE_THIRD_SHAKE, 8'h00, 8'h00, 2));
        send_datagram(make_packet(TYPE_FIRST_SHAKE, 8'hFF, 8'hFF, 5));

        // await third shake: repeated first shake, then the third
        send_datagram(make_packet(TYPE_FIRST_SHAKE, 8'h00, 8'h00, 2));
        send_datagram(make_packet(TYPE_THIRD_SHAKE, 8'h00, 8'h00, 2));
        drain_replies();

        // transfer: one-byte packet, wrong sequence, corrupt, no length byte, last
        send_datagram(make_packet(8'h00, 8'h00, 8'h00, 1));
        send_datagram(make_packet(8'h02, sb.exp_seq + 8'd3, 8'h10, 6));
        dg = make_packet(8'h00, sb.exp_seq, 8'h20, 4);
        dg[0] ^= 8'h01;
        send_datagram(dg);
        send_datagram(make_packet(8'hFF, sb.exp_seq, 8'hFF, 3));
        send_datagram(make_packet(TYPE_LAST, sb.exp_seq, 8'hFF, 6));
        drain_replies();

        while (sb.phase == PH_XFER) begin
            if (sb.accepted_count >= 75) quiet_tail = 1'b1;
            if (sb.accepted_count >= 90) begin
                dg = make_packet(TYPE_LAST, sb.exp_seq, 8'h00, $urandom_range(4, 8));
            end else if (!long_sent && sb.accepted_count >= 40) begin
                dg = make_packet(pick_data_type(), sb.exp_seq, 8'($urandom),
                                 DATA_DATAGRAM_BYTES + 3);
                long_sent = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 78) begin
                    dg = make_packet(pick_data_type(), sb.exp_seq, 8'($urandom),
                                     $urandom_range(2, 5));
                end else if (pick < 86) begin
                    dg = make_packet(pick_data_type(), sb.exp_seq + 8'($urandom_range(1, 255)),
                                     8'($urandom), $urandom_range(3, 6));
                end else if (pick < 94) begin
                    dg = make_packet(($urandom_range(0, 1) == 0) ? TYPE_LAST : pick_data_type(),
                                     sb.exp_seq, 8'($urandom), $urandom_range(1, 6));
                    dg[0] ^= 8'h01;
                end else begin
                    dg.delete();
                    repeat ($urandom_range(1, 4)) dg.push_back(8'($urandom));
                end
            end
            send_datagram(dg);
            if (sb.accepted_count == 60) drain_replies();
        end

        // close: ignored types and a corrupt wave, then a wave with a trailing byte
        send_datagram(make_packet(TYPE_ACK, 8'h00, 8'h00, 2));
        dg = make_packet(TYPE_FIRST_WAVE, 8'h00, 8'h00, 2);
        dg[0] ^= 8'h01;
        send_datagram(dg);
        send_datagram(make_packet(8'h00, 8'h00, 8'h00, 1));
        send_datagram(make_packet(TYPE_FIRST_WAVE, 8'($urandom), 8'($urandom), 3));

        // done: everything is ignored
        send_datagram(make_packet(TYPE_FIRST_SHAKE, 8'h00, 8'h00, 2));
        repeat (5) send_datagram(make_packet(8'($urandom), 8'($urandom), 8'($urandom),
                                             $urandom_range(1, 5)));

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d datagrams, %0d replies checked, %0d data packets accepted",
                 sb.datagram_count, sb.checked_count, sb.accepted_count);
        $display("Walked handshake, %0d messages and close; final phase %0d",
                 MESSAGES, sb.phase);
        if (sb.mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
